@@ src/ttc_pkg.sv @@
// ---------------------------------------------------------------------------
// ttc_pkg
// Types and codes shared by the timed thermostat controller modules.
// ---------------------------------------------------------------------------
package ttc_pkg;

   // one sample of time, date and temperature
   typedef struct packed {
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
      logic [4:0]        day_of_month;
      logic [3:0]        month_now;
      logic [6:0]        year_now;
      logic signed [7:0] temp_whole;
      logic [6:0]        temp_fraction;
   } ttc_req_type;

   typedef struct packed {
      logic system_active;
      logic heater_drive;
      logic buzz_pulse;
      logic buzz_is_hot;
   } ttc_rsp_type;

   // most significant field first, so a plain unsigned compare orders two stamps
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } ttc_stamp_type;

   typedef struct packed {
      logic signed [7:0] trigger_whole;
      logic [6:0]        trigger_fraction;
      logic [5:0]        hot_delay_secs;
      logic [6:0]        cold_delay_secs;
   } ttc_cfg_type;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 8;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TRIGGER_WHOLE    = 2'd0,
      CSR_TRIGGER_FRACTION = 2'd1,
      CSR_HOT_DELAY        = 2'd2,
      CSR_COLD_DELAY       = 2'd3
   } ttc_csr_index_type;

endpackage

@@ src/timed_thermostat_controller_core.sv @@
// ---------------------------------------------------------------------------
// timed_thermostat_controller_core
// Time-windowed thermostat: one result per time/temperature sample.
// ---------------------------------------------------------------------------
// Each accepted sample produces exactly one result, which moves on once the
// result register is free. The sample is captured in an input register. The
// whole decision (window, hot compare, deadline carry chain, expiry compare,
// state update) settles in one combinational pass, and the result lands in an
// output register. A new sample can be accepted every cycle while rsp_ready is
// high. While a finished result waits on rsp_ready, one more sample is taken
// into the input register. After that req_ready stays low until the result
// drains. Configuration writes are taken at any time through the csr channel
// and should be made while no sample is in flight. No memory, no clearing
// pass after reset.
module timed_thermostat_controller_core import ttc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ttc_req_type             req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ttc_rsp_type             rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   ttc_cfg_type cfg_ff;
   logic        in_valid_ff;
   ttc_req_type in_data_ff;
   logic        out_valid_ff;
   ttc_rsp_type out_data_ff;
   ttc_rsp_type result;
   logic        advance;
   ttc_csr_index_type csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = ttc_csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_whole    <= 8'sd30;
         cfg_ff.trigger_fraction <= 7'd0;
         cfg_ff.hot_delay_secs   <= 6'd5;
         cfg_ff.cold_delay_secs  <= 7'd5;
      end else if (csr_valid) begin
         case (csr_sel)
            CSR_TRIGGER_WHOLE: begin
               cfg_ff.trigger_whole <= $signed(csr_data);
            end
            CSR_TRIGGER_FRACTION: begin
               cfg_ff.trigger_fraction <= csr_data[6:0];
            end
            CSR_HOT_DELAY: begin
               cfg_ff.hot_delay_secs <= csr_data[5:0];
            end
            CSR_COLD_DELAY: begin
               cfg_ff.cold_delay_secs <= csr_data[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   // the stage moves when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   ttc_state u_state (
      .clock    (clock),
      .reset    (reset),
      .step_i   (advance),
      .sample_i (in_data_ff),
      .cfg_i    (cfg_ff),
      .result_o (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ src/ttc_goal_calc.sv @@
// ---------------------------------------------------------------------------
// ttc_goal_calc
// Deadline arithmetic: sample time plus the hot or cold delay, with carries
// through minutes, hours, days, months and years.
// ---------------------------------------------------------------------------
module ttc_goal_calc import ttc_pkg::*; (
   input  ttc_stamp_type now_i,
   input  logic          hot_i,
   input  ttc_cfg_type   cfg_i,
   output ttc_stamp_type goal_o
);

   localparam logic [7:0] SecOne   = 8'd60;
   localparam logic [7:0] SecTwo   = 8'd120;
   localparam logic [7:0] SecThree = 8'd180;
   localparam logic [6:0] MinLast  = 7'd59;
   localparam logic [6:0] MinFull  = 7'd60;
   localparam logic [5:0] HourLast = 6'd23;
   localparam logic [3:0] MonLast  = 4'd12;
   localparam logic [6:0] LeapSkip = 7'd100;

   logic [7:0] sec_sum;
   logic [1:0] min_carry;
   logic [5:0] sec_rem;
   logic [6:0] min_sum;
   logic [5:0] min_rem;
   logic [5:0] hour_sum;
   logic       leap;
   logic [4:0] month_days;
   logic [4:0] day_inc;
   logic [3:0] mon_inc;
   logic [6:0] year_inc;

   always_comb begin
      sec_sum = {2'b00, now_i.second} +
                (hot_i ? {2'b00, cfg_i.hot_delay_secs} : {1'b0, cfg_i.cold_delay_secs});
      if (sec_sum >= SecThree) begin
         min_carry = 2'd3;
         sec_rem   = 6'(sec_sum - SecThree);
      end else if (sec_sum >= SecTwo) begin
         min_carry = 2'd2;
         sec_rem   = 6'(sec_sum - SecTwo);
      end else if (sec_sum >= SecOne) begin
         min_carry = 2'd1;
         sec_rem   = 6'(sec_sum - SecOne);
      end else begin
         min_carry = 2'd0;
         sec_rem   = sec_sum[5:0];
      end

      min_sum = {1'b0, now_i.minute} + {5'b00000, min_carry};
      if (min_sum > MinLast) begin
         hour_sum = {1'b0, now_i.hour} + 6'd1;
         min_rem  = 6'(min_sum - MinFull);
      end else begin
         hour_sum = {1'b0, now_i.hour};
         min_rem  = min_sum[5:0];
      end

      // years are 2000 based: 2000 is a leap year, 2100 is not
      leap = (now_i.year[1:0] == 2'b00) && (now_i.year != LeapSkip);
      case (now_i.month)
         4'd2: begin
            month_days = leap ? 5'd29 : 5'd28;
         end
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
            month_days = 5'd31;
         end
         default: begin
            month_days = 5'd30;
         end
      endcase

      day_inc  = now_i.day + 5'd1;
      mon_inc  = now_i.month + 4'd1;
      year_inc = now_i.year + 7'd1;

      goal_o        = now_i;
      goal_o.second = sec_rem;
      goal_o.minute = min_rem;
      goal_o.hour   = hour_sum[4:0];
      if (hour_sum > HourLast) begin
         goal_o.hour = 5'd0;
         goal_o.day  = day_inc;
         if (day_inc > month_days) begin
            goal_o.day   = 5'd1;
            goal_o.month = mon_inc;
            if (mon_inc > MonLast) begin
               goal_o.month = 4'd1;
               goal_o.year  = year_inc;
            end
         end
      end
   end

endmodule

@@ src/ttc_state.sv @@
// ---------------------------------------------------------------------------
// ttc_state
// Per-sample decision logic and controller state: window tracking, hot/cold
// detection, deadline update and expiry, heater latch.
// ---------------------------------------------------------------------------
module ttc_state import ttc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_i,
   input  ttc_req_type sample_i,
   input  ttc_cfg_type cfg_i,
   output ttc_rsp_type result_o
);

   localparam logic [4:0] WinOpenHour  = 5'd7;
   localparam logic [4:0] WinCloseHour = 5'd22;
   localparam logic [5:0] WinCloseMin  = 6'd30;

   logic          rearm_ff, rearm_in;
   logic          prev_hot_ff, prev_hot_in;
   logic          prev_win_ff, prev_win_in;
   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic          latch_ff, latch_in;
   logic          heater_ff, heater_in;
   ttc_stamp_type goal_ff, goal_in;

   ttc_stamp_type now_stamp;
   ttc_stamp_type new_goal;
   logic          win;
   logic          hot;
   logic          win_change;
   logic          prev_hot_a;
   logic          done_a;
   logic          flip;
   logic          set_goal;
   logic          done_b;
   logic          fire;

   assign now_stamp = '{year:   sample_i.year_now,
                        month:  sample_i.month_now,
                        day:    sample_i.day_of_month,
                        hour:   sample_i.hour,
                        minute: sample_i.minute,
                        second: sample_i.second};

   ttc_goal_calc u_goal_calc (
      .now_i  (now_stamp),
      .hot_i  (hot),
      .cfg_i  (cfg_i),
      .goal_o (new_goal)
   );

   always_comb begin
      win = !((sample_i.hour > WinCloseHour) ||
              ((sample_i.hour == WinCloseHour) && (sample_i.minute >= WinCloseMin)) ||
              (sample_i.hour < WinOpenHour));
      hot = (sample_i.temp_whole > cfg_i.trigger_whole) ||
            ((sample_i.temp_whole == cfg_i.trigger_whole) &&
             (sample_i.temp_fraction >= cfg_i.trigger_fraction));

      // a pending re-arm snapshots the sample first
      prev_hot_a = rearm_ff ? hot : prev_hot_ff;
      done_a     = rearm_ff ? 1'b0 : done_ff;
      win_change = rearm_ff ? 1'b0 : (win != prev_win_ff);
      active_in  = (rearm_ff || win_change) ? win : active_ff;
      rearm_in   = win_change && win;
      prev_win_in = win;

      flip     = active_in && (hot != prev_hot_a);
      set_goal = rearm_ff || flip;
      goal_in  = set_goal ? new_goal : goal_ff;
      done_b   = flip ? 1'b0 : done_a;
      prev_hot_in = active_in ? hot : prev_hot_a;

      fire      = active_in && !done_b && (now_stamp >= goal_in);
      done_in   = done_b || fire;
      latch_in  = fire ? !hot : latch_ff;
      heater_in = active_in ? latch_in : heater_ff;

      result_o.system_active = active_in;
      result_o.heater_drive  = heater_in;
      result_o.buzz_pulse    = fire;
      result_o.buzz_is_hot   = fire && hot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rearm_ff    <= 1'b1;
         prev_hot_ff <= 1'b0;
         prev_win_ff <= 1'b0;
         active_ff   <= 1'b0;
         done_ff     <= 1'b0;
         latch_ff    <= 1'b0;
         heater_ff   <= 1'b0;
         goal_ff     <= '{year: 7'd0, month: 4'd1, day: 5'd1,
                          hour: 5'd0, minute: 6'd0, second: 6'd0};
      end else if (step_i) begin
         rearm_ff    <= rearm_in;
         prev_hot_ff <= prev_hot_in;
         prev_win_ff <= prev_win_in;
         active_ff   <= active_in;
         done_ff     <= done_in;
         latch_ff    <= latch_in;
         heater_ff   <= heater_in;
         goal_ff     <= goal_in;
      end
   end

   a_fire_marks_done: assert property (@(posedge clock) disable iff (reset)
      step_i && fire |=> done_ff)
      else $error("deadline expiry not recorded");

   a_no_second_buzz: assert property (@(posedge clock) disable iff (reset)
      step_i && done_ff && !set_goal |-> !fire)
      else $error("buzz repeated without a new deadline");

   a_heater_held_inactive: assert property (@(posedge clock) disable iff (reset)
      step_i && !active_in |=> heater_ff == $past(heater_ff))
      else $error("heater changed outside the window");

   a_prev_hot_tracks: assert property (@(posedge clock) disable iff (reset)
      step_i && active_in |=> prev_hot_ff == $past(hot))
      else $error("hot history not updated while active");

endmodule

@@ tb/timed_thermostat_controller_core_test.sv @@
// ---------------------------------------------------------------------------
// timed_thermostat_controller_core_test
// Drives time/temperature samples through the controller with random gaps and
// result stalls. A local model of the window, hot compare, deadline carries
// and expiry decides each expected result not typed by hand, and every result
// beat is compared field by field. A short table of hand-picked samples comes
// first, then runs of realistic clock progressions under several trigger/delay
// settings, with some raw noise samples mixed in.
// ---------------------------------------------------------------------------
module timed_thermostat_controller_core_test import ttc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      ttc_req_type smp;
      bit          typed;
      ttc_rsp_type result;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   ttc_req_type              req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   ttc_rsp_type              rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   // hand-typed expectation travelling with the sample beat
   logic                     announced_typed;
   ttc_rsp_type              announced_result;

   // local copy of the controller state
   ttc_cfg_type              setpoint;
   bit                       rearm_due;
   bit                       last_hot;
   bit                       last_in_window;
   bit                       running;
   bit                       deadline_hit;
   bit                       heat_request;
   bit                       heater_now;
   ttc_stamp_type            goal;

   ttc_rsp_type              awaited_results[$];
   directed_row_type         directed_rows[$];
   int                       failures;
   bit                       steady_flow;

   // wall clock for well-formed sample runs
   int unsigned              wall_hour;
   int unsigned              wall_minute;
   int unsigned              wall_second;
   int unsigned              wall_day;
   int unsigned              wall_month;
   int unsigned              wall_year;
   int                       temp_drift;

   timed_thermostat_controller_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("timed_thermostat_controller_core test failed");
      $finish;
   end

   function automatic int unsigned days_in_month(int unsigned mo, int unsigned yr);
      int unsigned full;
      bit          leap;
      full = 2000 + yr;
      leap = (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
      case (mo)
         2: return leap ? 29 : 28;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default: return 30;
      endcase
   endfunction

   function automatic ttc_stamp_type deadline_from(bit hot, ttc_req_type smp);
      int unsigned   s, m, h, d, mo, y;
      ttc_stamp_type stamp;
      s = smp.second;
      s += hot ? setpoint.hot_delay_secs : setpoint.cold_delay_secs;
      m = smp.minute;
      h = smp.hour;
      d = smp.day_of_month;
      mo = smp.month_now;
      y = smp.year_now;
      if (s > 59) begin
         m += s / 60;
         s %= 60;
      end
      if (m > 59) begin
         h += m / 60;
         m %= 60;
      end
      // any hour overflow moves exactly one day on
      if (h > 23) begin
         h = 0;
         d = (d + 1) % 32;
         if (d > days_in_month(mo, y)) begin
            d = 1;
            mo = (mo + 1) % 16;
            if (mo > 12) begin
               mo = 1;
               y = (y + 1) % 128;
            end
         end
      end
      stamp.year = y[6:0];
      stamp.month = mo[3:0];
      stamp.day = d[4:0];
      stamp.hour = h[4:0];
      stamp.minute = m[5:0];
      stamp.second = s[5:0];
      return stamp;
   endfunction

   function automatic ttc_rsp_type next_thermostat_result(ttc_req_type smp);
      ttc_rsp_type   res;
      ttc_stamp_type now;
      bit            in_window;
      bit            hot;
      res = '0;
      now = {smp.year_now, smp.month_now, smp.day_of_month, smp.hour, smp.minute,
             smp.second};
      in_window = !(smp.hour > 22 || (smp.hour == 22 && smp.minute >= 30) || smp.hour < 7);
      hot = (smp.temp_whole > setpoint.trigger_whole) ||
            (smp.temp_whole == setpoint.trigger_whole &&
             smp.temp_fraction >= setpoint.trigger_fraction);
      if (rearm_due) begin
         rearm_due = 1'b0;
         last_hot = hot;
         last_in_window = in_window;
         running = in_window;
         goal = deadline_from(hot, smp);
         deadline_hit = 1'b0;
      end
      if (in_window != last_in_window) begin
         running = in_window;
         rearm_due = in_window;
      end
      last_in_window = in_window;
      if (running) begin
         if (hot != last_hot) begin
            goal = deadline_from(hot, smp);
            deadline_hit = 1'b0;
         end
         last_hot = hot;
         // stamp fields run most significant first, so one compare orders them
         if (!deadline_hit && now >= goal) begin
            res.buzz_pulse = 1'b1;
            res.buzz_is_hot = hot;
            deadline_hit = 1'b1;
            heat_request = !hot;
         end
         heater_now = heat_request;
      end
      res.system_active = running;
      res.heater_drive = heater_now;
      return res;
   endfunction

   task automatic check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      ttc_rsp_type oldest;
      if (reset) begin
         setpoint = '{8'sd30, 7'd0, 6'd5, 7'd5};
         rearm_due = 1'b1;
         last_hot = 1'b0;
         last_in_window = 1'b0;
         running = 1'b0;
         deadline_hit = 1'b0;
         heat_request = 1'b0;
         heater_now = 1'b0;
         goal = '0;
         goal.day = 5'd1;
         goal.month = 4'd1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRIGGER_WHOLE:    setpoint.trigger_whole = csr_data;
               CSR_TRIGGER_FRACTION: setpoint.trigger_fraction = csr_data[6:0];
               CSR_HOT_DELAY:        setpoint.hot_delay_secs = csr_data[5:0];
               CSR_COLD_DELAY:       setpoint.cold_delay_secs = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            oldest = next_thermostat_result(req_data);
            awaited_results.push_back(announced_typed ? announced_result : oldest);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result beat with nothing awaited");
               failures++;
            end else begin
               oldest = awaited_results.pop_front();
               check_field("system_active", oldest.system_active, rsp_data.system_active);
               check_field("heater_drive", oldest.heater_drive, rsp_data.heater_drive);
               check_field("buzz_pulse", oldest.buzz_pulse, rsp_data.buzz_pulse);
               check_field("buzz_is_hot", oldest.buzz_is_hot, rsp_data.buzz_is_hot);
            end
         end
      end
   end

   // mostly short gaps, a few long ones, none at all while the flow is steady
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   initial begin
      int unsigned hold;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         hold = idle_cycles();
         if (hold == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
         end
      end
   end

   function automatic void advance_wall(int unsigned secs);
      int unsigned total;
      total = wall_second + 60 * (wall_minute + 60 * wall_hour) + secs;
      wall_second = total % 60;
      wall_minute = (total / 60) % 60;
      wall_hour = total / 3600;
      while (wall_hour > 23) begin
         wall_hour -= 24;
         wall_day++;
         if (wall_day > days_in_month(wall_month, wall_year)) begin
            wall_day = 1;
            wall_month++;
            if (wall_month > 12) begin
               wall_month = 1;
               wall_year = (wall_year + 1) % 100;
            end
         end
      end
   endfunction

   function automatic ttc_req_type random_sample(ttc_cfg_type sp);
      ttc_req_type smp;
      logic [63:0] noise;
      int unsigned pick;
      int          level;
      int          whole;
      int          frac;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         noise = {$urandom, $urandom};
         return noise[47:0];
      end
      if (pick < 85) advance_wall($urandom_range(0, 8));
      else if (pick < 96) advance_wall($urandom_range(9, 400));
      else advance_wall($urandom_range(401, 40000));
      // temperature wanders around the trigger so hot/cold keeps flipping
      temp_drift += int'($urandom_range(0, 30)) - 15;
      if (temp_drift > 250) temp_drift = 250;
      if (temp_drift < -250) temp_drift = -250;
      level = int'(sp.trigger_whole) * 100 + int'(sp.trigger_fraction) + temp_drift;
      whole = (level >= 0) ? level / 100 : -((99 - level) / 100);
      frac = level - whole * 100;
      smp.hour = wall_hour[4:0];
      smp.minute = wall_minute[5:0];
      smp.second = wall_second[5:0];
      smp.day_of_month = wall_day[4:0];
      smp.month_now = wall_month[3:0];
      smp.year_now = wall_year[6:0];
      smp.temp_whole = whole[7:0];
      smp.temp_fraction = frac[6:0];
      return smp;
   endfunction

   function automatic directed_row_type vector_row(int hr, int mi, int se, int dy, int mo,
                                                   int yr, int tw, int tf, int typed = -1);
      directed_row_type r;
      r.smp.hour = hr[4:0];
      r.smp.minute = mi[5:0];
      r.smp.second = se[5:0];
      r.smp.day_of_month = dy[4:0];
      r.smp.month_now = mo[3:0];
      r.smp.year_now = yr[6:0];
      r.smp.temp_whole = tw[7:0];
      r.smp.temp_fraction = tf[6:0];
      r.typed = (typed >= 0);
      r.result = typed[3:0];
      return r;
   endfunction

   function automatic ttc_cfg_type phase_setpoint(int ph);
      ttc_cfg_type sp;
      case (ph)
         0: sp = '{8'sd0, 7'd50, 6'd3, 7'd7};
         1: sp = '{8'sh80, 7'd0, 6'd0, 7'd0};
         2: sp = '{8'sd127, 7'd127, 6'd63, 7'd127};
         3: sp = '{-8'sd55, 7'd0, 6'd60, 7'd90};
         4: sp = '{8'sd125, 7'd99, 6'd1, 7'd2};
         5: sp = '{8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                   6'($urandom_range(0, 63)), 7'($urandom_range(0, 127))};
         default: sp = '{8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                         6'($urandom_range(0, 15)), 7'($urandom_range(0, 15))};
      endcase
      return sp;
   endfunction

   task automatic send_sample(ttc_req_type smp, bit typed, ttc_rsp_type typed_result);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= smp;
      announced_typed <= typed;
      announced_result <= typed_result;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop req_valid and let the last sample beat be counted before waiting on results
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic put_register(ttc_csr_index_type idx, logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_setpoints(ttc_cfg_type sp);
      put_register(CSR_TRIGGER_WHOLE, sp.trigger_whole);
      put_register(CSR_TRIGGER_FRACTION, {1'b0, sp.trigger_fraction});
      put_register(CSR_HOT_DELAY, {2'b0, sp.hot_delay_secs});
      put_register(CSR_COLD_DELAY, {1'b0, sp.cold_delay_secs});
      csr_valid <= 1'b0;
   endtask

   initial begin
      ttc_cfg_type next_setpoint;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TRIGGER_WHOLE;
      csr_data = '0;
      announced_typed = 1'b0;
      announced_result = '0;
      failures = 0;
      steady_flow = 1'b0;
      wall_hour = 6;
      wall_minute = 50;
      wall_second = 0;
      wall_day = 28;
      wall_month = 2;
      wall_year = 0;
      temp_drift = 0;

      // hour min sec day month year whole fraction [typed result]
      directed_rows.push_back(vector_row( 6, 59, 59,  1,  1,   0,   20,   0, 4'b0000));
      directed_rows.push_back(vector_row( 7,  0,  0,  1,  1,   0,   20,   0));
      directed_rows.push_back(vector_row( 7,  0,  2,  1,  1,   0,   30,   0));
      directed_rows.push_back(vector_row( 7,  0,  7,  1,  1,   0,   30,   0, 4'b1011));
      directed_rows.push_back(vector_row( 7,  0,  8,  1,  1,   0,   29,  99));
      directed_rows.push_back(vector_row( 7,  0, 13,  1,  1,   0,   29,  99, 4'b1110));
      directed_rows.push_back(vector_row(22, 30,  0,  1,  1,   0,   30,  50, 4'b0100));
      directed_rows.push_back(vector_row(22, 29, 59,  1,  1,   0,  127, 127));
      directed_rows.push_back(vector_row(23, 59, 58, 30, 11,  99, -128,   0));
      directed_rows.push_back(vector_row(12,  0,  0,  1,  1,   0,   30,   0));
      directed_rows.push_back(vector_row(23, 59, 58, 30, 13, 127,    0,   0));
      directed_rows.push_back(vector_row( 7,  0,  0, 28,  2,   0,   31,   0));
      directed_rows.push_back(vector_row(23, 59, 58, 28,  2,   0,   29,  99));
      directed_rows.push_back(vector_row(21, 59,  0, 29,  2,   0,   30,   0));
      directed_rows.push_back(vector_row(23, 59, 59, 29,  2,   0,   29,   0));
      directed_rows.push_back(vector_row( 8,  0,  0, 28,  2, 100,   30,   0));
      directed_rows.push_back(vector_row(23, 59, 59, 28,  2, 100,   29,   0));
      directed_rows.push_back(vector_row(21, 59, 57, 31, 15,   4,   20,   0));
      directed_rows.push_back(vector_row(23, 59, 59, 30, 15,   4,   20,   0));
      directed_rows.push_back(vector_row(21, 63, 63,  1,  1,   0,   30,   0));
      directed_rows.push_back(vector_row(31,  0,  0,  0,  0,   0,   30,   0));
      directed_rows.push_back(vector_row(22, 29, 59, 31, 15, 127,   30,   1));
      directed_rows.push_back(vector_row( 7,  0,  0, 31, 15, 127,  -55,   0));
      directed_rows.push_back(vector_row( 7,  0,  5, 31, 15, 127,  -55,   0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].result);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         next_setpoint = phase_setpoint(ph);
         write_setpoints(next_setpoint);
         repeat (238) begin
            if ($urandom_range(0, 59) == 0) steady_flow = !steady_flow;
            send_sample(random_sample(next_setpoint), 1'b0, '0);
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (failures == 0 && awaited_results.size() == 0) begin
         $display("timed_thermostat_controller_core test passed");
      end else begin
         $display("timed_thermostat_controller_core test failed");
      end
      $finish;
   end

endmodule
